// ----- sv/cnpj_check_digit_validator_assert.svh -----
// ----------------------------------------------------------------------------
// CNPJ validator assertion macros
// Shared property forms for the validator's checker.
// ----------------------------------------------------------------------------
`ifndef CNPJ_CHECK_DIGIT_VALIDATOR_ASSERT_SVH
`define CNPJ_CHECK_DIGIT_VALIDATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cdv_pkg.sv -----
// ----------------------------------------------------------------------------
// CNPJ validator package
// Types, constants and small helper functions for the check-digit datapath.
// ----------------------------------------------------------------------------
package cdv_pkg;

  typedef logic [3:0] pos_t;   // character position, saturating
  typedef logic [3:0] res_t;   // residue modulo 11
  typedef logic [3:0] digit_t; // decimal digit value
  typedef logic [7:0] char_t;  // ASCII character

  localparam char_t ASCII_ZERO = 8'd48;
  localparam char_t ASCII_NINE = 8'd57;

  localparam pos_t FIRST_CHECK_POS  = 4'd12;
  localparam pos_t SECOND_CHECK_POS = 4'd13;
  localparam pos_t BRANCH_POS_HI    = 4'd8;
  localparam pos_t BRANCH_POS_LO    = 4'd9;
  localparam pos_t POS_MAX          = 4'd15;

  localparam res_t MOD_BASE = 4'd11;

  // Weights of the first check digit, positions 0 to 11.
  function automatic digit_t weight_first(input pos_t pos);
    digit_t w;
    case (pos)
      4'd0:    w = 4'd5;
      4'd1:    w = 4'd4;
      4'd2:    w = 4'd3;
      4'd3:    w = 4'd2;
      4'd4:    w = 4'd9;
      4'd5:    w = 4'd8;
      4'd6:    w = 4'd7;
      4'd7:    w = 4'd6;
      4'd8:    w = 4'd5;
      4'd9:    w = 4'd4;
      4'd10:   w = 4'd3;
      4'd11:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Weights of the second check digit, positions 0 to 12.
  function automatic digit_t weight_second(input pos_t pos);
    digit_t w;
    case (pos)
      4'd0:    w = 4'd6;
      4'd1:    w = 4'd5;
      4'd2:    w = 4'd4;
      4'd3:    w = 4'd3;
      4'd4:    w = 4'd2;
      4'd5:    w = 4'd9;
      4'd6:    w = 4'd8;
      4'd7:    w = 4'd7;
      4'd8:    w = 4'd6;
      4'd9:    w = 4'd5;
      4'd10:   w = 4'd4;
      4'd11:   w = 4'd3;
      4'd12:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Reduces a value below 128 modulo 11 by four conditional subtractions.
  function automatic res_t mod11(input logic [6:0] x);
    logic [6:0] v;
    v = x;
    if (v >= 7'd88) v = v - 7'd88;
    if (v >= 7'd44) v = v - 7'd44;
    if (v >= 7'd22) v = v - 7'd22;
    if (v >= 7'd11) v = v - 7'd11;
    return v[3:0];
  endfunction

  // Adds digit times weight to a residue and reduces the result.
  function automatic res_t mac_mod11(input res_t r, input digit_t d, input digit_t w);
    logic [6:0] prod;
    prod = 7'(d * w);
    return mod11(7'(prod + 7'(r)));
  endfunction

  // A residue below 2 gives 0, any other gives 11 minus the residue.
  function automatic digit_t check_digit(input res_t r);
    return (r < 4'd2) ? 4'd0 : digit_t'(MOD_BASE - r);
  endfunction

endpackage

// ----- sv/cnpj_check_digit_validator.sv -----
// ----------------------------------------------------------------------------
// CNPJ check-digit validator
// Streams a company number character by character and reports whether it
// is well formed and carries correct modulo-11 check digits.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one ASCII character per
// request, first character first, with in_last_char set on the final one.
// Only the request that carries the last mark produces a result request on
// the output channel (out_valid/out_ready) with out_cnpj_valid.
// The configuration channel (cfg_valid/cfg_ready) writes the branch check
// enable; cfg_ready is always high. Write it only while the block is idle.
// A last character is first held in the input register, and its verdict is then loaded
// into the output register when the input stage passes that character on.
// Throughput: one character per cycle while in_ready is high. The single pass through
// the two position weight tables, two small multiplies and the mod-11 reductions
// limits the clock, not the rate.
// Reset clears the position count, both residues and both pipeline valids, and sets
// the running flag and the branch check enable.
// When the receiver stalls, the result waits in the output register; one
// more last character can sit in the input register behind it, and the
// input channel stalls only then. Characters without the last mark keep
// flowing because they produce no result.
// ----------------------------------------------------------------------------
module cnpj_check_digit_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_cnpj_valid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_branch_zero_check
);

  // Input register stage.
  logic                 s1_valid_r;
  cdv_pkg::char_t       s1_char_r;
  logic                 s1_last_r;

  // Per-number running state. The two weighted sums are kept as residues
  // modulo 11; the sums never exceed 10 bits, so nothing wraps and the
  // residue is all the check digit needs.
  cdv_pkg::pos_t        pos_r,  pos_nxt;
  cdv_pkg::res_t        res1_r, res1_nxt;
  cdv_pkg::res_t        res2_r, res2_nxt;
  logic                 ok_r,   ok_nxt;

  logic                 branch_chk_r;

  // Output register.
  logic                 out_valid_r;
  logic                 out_cnpj_r, out_cnpj_nxt;

  logic                 s1_go;
  logic                 is_digit;
  cdv_pkg::digit_t      digit;

  // The input stage drains unless it holds a last character and the
  // output register is still waiting for the receiver.
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_cnpj_valid = out_cnpj_r;

  always_comb begin
    is_digit = s1_char_r inside {[cdv_pkg::ASCII_ZERO:cdv_pkg::ASCII_NINE]};
    digit    = is_digit ? cdv_pkg::digit_t'(s1_char_r - cdv_pkg::ASCII_ZERO) : 4'd0;

    ok_nxt   = ok_r && is_digit;
    res1_nxt = res1_r;
    res2_nxt = res2_r;

    if (pos_r < cdv_pkg::FIRST_CHECK_POS) begin
      res1_nxt = cdv_pkg::mac_mod11(res1_r, digit, cdv_pkg::weight_first(pos_r));
      res2_nxt = cdv_pkg::mac_mod11(res2_r, digit, cdv_pkg::weight_second(pos_r));
    end else if (pos_r == cdv_pkg::FIRST_CHECK_POS) begin
      if (cdv_pkg::check_digit(res1_r) != digit) ok_nxt = 1'b0;
      res2_nxt = cdv_pkg::mac_mod11(res2_r, digit, cdv_pkg::weight_second(pos_r));
    end else if (pos_r == cdv_pkg::SECOND_CHECK_POS) begin
      if (cdv_pkg::check_digit(res2_r) != digit) ok_nxt = 1'b0;
    end else begin
      // Too many characters.
      ok_nxt = 1'b0;
    end

    if ((pos_r == cdv_pkg::BRANCH_POS_HI || pos_r == cdv_pkg::BRANCH_POS_LO) &&
        branch_chk_r && (s1_char_r != cdv_pkg::ASCII_ZERO)) begin
      ok_nxt = 1'b0;
    end

    out_cnpj_nxt = ok_nxt && (pos_r == cdv_pkg::SECOND_CHECK_POS);

    pos_nxt = (pos_r == cdv_pkg::POS_MAX) ? pos_r : cdv_pkg::pos_t'(pos_r + 4'd1);

    // The last character closes the number and rearms the state.
    if (s1_last_r) begin
      pos_nxt  = '0;
      res1_nxt = '0;
      res2_nxt = '0;
      ok_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pos_r        <= '0;
      res1_r       <= '0;
      res2_r       <= '0;
      ok_r         <= 1'b1;
      branch_chk_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        branch_chk_r <= cfg_branch_zero_check;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        pos_r  <= pos_nxt;
        res1_r <= res1_nxt;
        res2_r <= res2_nxt;
        ok_r   <= ok_nxt;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last_char;
    end
    if (s1_go && s1_last_r) begin
      out_cnpj_r <= out_cnpj_nxt;
    end
  end

endmodule

// ----- sv/cdv_checker.sv -----
// ----------------------------------------------------------------------------
// CNPJ validator checker
// Port-level assertions for the validator, bound to its top level.
// ----------------------------------------------------------------------------
`include "cnpj_check_digit_validator_assert.svh"

module cdv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_cnpj_valid,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // A result waiting on the receiver stays offered and unchanged.
  `CDV_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped in stall")
  `CDV_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_cnpj_valid), "result changed in stall")

  // The input side only stalls behind a pending, stalled result.
  `CDV_ASSERT_NOW(a_in_stall_cause, !in_ready, out_stall, "input stalled with no stalled result")

  // Configuration writes are never refused.
  `CDV_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind cnpj_check_digit_validator cdv_checker u_cdv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cnpj_valid (out_cnpj_valid),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// CNPJ check-digit validator testbench
// Streams company numbers into the validator one character request at a time
// and checks every verdict against a cycle-free model of the scheme that runs
// beside it. Starts with a table of hand-picked numbers, then runs phases of
// random numbers, mostly well formed with correct check digits and the rest
// damaged in various ways, with random input gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  // The limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  // Drain time for both pipeline registers, plus slack, before the block is idle.
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_CHARS = 300;

  // Weight tables packed four bits per position, position 0 in the low nibble.
  localparam logic [47:0] FIRST_WEIGHTS  = 48'h2345_6789_2345;
  localparam logic [51:0] SECOND_WEIGHTS = 52'h2_3456_7892_3456;

  // How a directed row gets its verdict: typed in, or taken from the model.
  typedef enum logic [1:0] {
    VERDICT_ONE,
    VERDICT_ZERO,
    VERDICT_PREDICTED
  } verdict_kind_e;

  // One row of the directed table. A character may be overridden at sub_pos
  // so that bytes that do not print can be placed in a number.
  typedef struct {
    string          text;
    int             sub_pos;
    cdv_pkg::char_t sub_char;
    bit             mark_last;
    bit             branch_en;
    verdict_kind_e  kind;
  } directed_row_t;

  logic           clk                   = 1'b0;
  logic           rst_n                 = 1'b0;
  logic           in_valid              = 1'b0;
  logic           in_ready;
  cdv_pkg::char_t in_character          = '0;
  logic           in_last_char          = 1'b0;
  logic           out_valid;
  logic           out_ready             = 1'b0;
  logic           out_cnpj_valid;
  logic           cfg_valid             = 1'b0;
  logic           cfg_ready;
  logic           cfg_branch_zero_check = 1'b0;

  cnpj_check_digit_validator uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_character          (in_character),
    .in_last_char          (in_last_char),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_cnpj_valid        (out_cnpj_valid),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_branch_zero_check (cfg_branch_zero_check)
  );

  always #1 clk = ~clk;

  // Model state: the number being assembled and the branch check setting.
  cdv_pkg::pos_t num_pos;
  logic [9:0]    sum_first;
  logic [9:0]    sum_second;
  bit            num_ok;
  bit            branch_zero_en;

  // Verdicts still owed by the block, oldest first.
  bit          verdict_q[$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          chars_sent  = 0;
  // When set, neither side inserts gaps or stalls.
  bit          idle_free   = 1'b0;

  function automatic logic [3:0] check_digit_of(input logic [9:0] sum);
    int r;
    r = sum % 11;
    return (r < 2) ? 4'd0 : 4'(11 - r);
  endfunction

  task automatic clear_number();
    num_pos    = '0;
    sum_first  = '0;
    sum_second = '0;
    num_ok     = 1'b1;
  endtask

  // Folds one accepted character into the model. The verdict is only
  // meaningful when the character carries the last mark.
  task automatic absorb_char(input cdv_pkg::char_t ch, input bit lst, output bit verdict);
    cdv_pkg::pos_t p;
    bit            is_digit;
    logic [3:0]    d;
    bit            ok;
    p        = num_pos;
    is_digit = (ch >= cdv_pkg::ASCII_ZERO) && (ch <= cdv_pkg::ASCII_NINE);
    d        = is_digit ? 4'(ch - cdv_pkg::ASCII_ZERO) : 4'd0;
    ok       = num_ok && is_digit;
    // A non-digit contributes nothing to either sum.
    if (p < cdv_pkg::FIRST_CHECK_POS) begin
      sum_first  = sum_first + d * FIRST_WEIGHTS[p * 4 +: 4];
      sum_second = sum_second + d * SECOND_WEIGHTS[p * 4 +: 4];
    end else if (p == cdv_pkg::FIRST_CHECK_POS) begin
      if (check_digit_of(sum_first) != d) ok = 1'b0;
      sum_second = sum_second + d * SECOND_WEIGHTS[p * 4 +: 4];
    end else if (p == cdv_pkg::SECOND_CHECK_POS) begin
      if (check_digit_of(sum_second) != d) ok = 1'b0;
    end else begin
      // Anything past the fourteenth character spoils the number.
      ok = 1'b0;
    end
    if ((p == cdv_pkg::BRANCH_POS_HI || p == cdv_pkg::BRANCH_POS_LO) &&
        branch_zero_en && ch != cdv_pkg::ASCII_ZERO)
      ok = 1'b0;
    num_ok = ok;
    if (num_pos != cdv_pkg::POS_MAX) num_pos = num_pos + 1'b1;
    verdict = ok && (p == cdv_pkg::SECOND_CHECK_POS);
    if (lst) clear_number();
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int pick_gap();
    int r;
    if (idle_free) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offers one character request and waits until the block takes it. Valid is
  // left high on return so that a following request can go out without a gap.
  task automatic push_char(input cdv_pkg::char_t ch, input bit lst,
                           input verdict_kind_e kind);
    int gap;
    bit predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last_char <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_char(ch, lst, predicted);
    chars_sent++;
    if (lst) begin
      case (kind)
        VERDICT_ONE:  verdict_q.push_back(1'b1);
        VERDICT_ZERO: verdict_q.push_back(1'b0);
        default:      verdict_q.push_back(predicted);
      endcase
    end
  endtask

  // The register may only change while the block is idle, so the input side
  // is parked, every owed verdict is collected and the pipeline drains first.
  task automatic write_branch_check(input bit enable);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid             <= 1'b1;
    cfg_branch_zero_check <= enable;
    do @(posedge clk); while (!cfg_ready);
    branch_zero_en = enable;
    cfg_valid      <= 1'b0;
  endtask

  // Builds a number with correct check digits, then, about half the time,
  // damages it: a wrong digit, a short or long number, a stray byte, two
  // digits swapped, or plain garbage of random length.
  task automatic send_random_number();
    cdv_pkg::char_t seq[$];
    logic [9:0]     s1;
    logic [9:0]     s2;
    logic [3:0]     dig;
    logic [3:0]     c1;
    logic [3:0]     c2;
    cdv_pkg::char_t held;
    int             r;
    int             k;
    s1 = '0;
    s2 = '0;
    for (int i = 0; i < 12; i++) begin
      // Keep the branch digits at zero often enough to pass that check.
      if ((i == 8 || i == 9) && $urandom_range(99) < (branch_zero_en ? 85 : 40))
        dig = 4'd0;
      else
        dig = 4'($urandom_range(9));
      s1 = s1 + dig * FIRST_WEIGHTS[i * 4 +: 4];
      s2 = s2 + dig * SECOND_WEIGHTS[i * 4 +: 4];
      seq.push_back(cdv_pkg::char_t'(cdv_pkg::ASCII_ZERO + dig));
    end
    c1 = check_digit_of(s1);
    s2 = s2 + c1 * SECOND_WEIGHTS[48 +: 4];
    c2 = check_digit_of(s2);
    seq.push_back(cdv_pkg::char_t'(cdv_pkg::ASCII_ZERO + c1));
    seq.push_back(cdv_pkg::char_t'(cdv_pkg::ASCII_ZERO + c2));

    r = $urandom_range(99);
    if (r >= 93) begin
      k = $urandom_range(12);
      held       = seq[k];
      seq[k]     = seq[k + 1];
      seq[k + 1] = held;
    end else if (r >= 86) begin
      seq.delete();
      k = $urandom_range(20, 1);
      repeat (k) seq.push_back(cdv_pkg::char_t'($urandom_range(255)));
    end else if (r >= 79) begin
      seq[$urandom_range(13)] = cdv_pkg::char_t'($urandom_range(255));
    end else if (r >= 72) begin
      k = $urandom_range(6, 1);
      repeat (k) seq.push_back(cdv_pkg::char_t'(cdv_pkg::ASCII_ZERO + $urandom_range(9)));
    end else if (r >= 65) begin
      k = $urandom_range(13, 1);
      repeat (k) void'(seq.pop_back());
    end else if (r >= 55) begin
      seq[$urandom_range(13)] = cdv_pkg::char_t'(cdv_pkg::ASCII_ZERO + $urandom_range(9));
    end

    foreach (seq[i]) push_char(seq[i], i == seq.size() - 1, VERDICT_PREDICTED);
  endtask

  // Receiver pacing: runs of ready, broken by stalls of random length.
  initial begin : result_pacing
    int run;
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      run = $urandom_range(12, 1);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Every result request is matched against the oldest owed verdict.
  always @(posedge clk) begin : result_check
    logic wanted;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("verdict %b arrived with no number pending", out_cnpj_valid));
      end else begin
        wanted = verdict_q.pop_front();
        if (out_cnpj_valid !== wanted)
          flag_mismatch($sformatf("cnpj_valid is %b, model says %b", out_cnpj_valid, wanted));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t  rows[$];
    cdv_pkg::char_t ch;
    int             len;
    int             start_count;
    int             phase;

    clear_number();
    branch_zero_en = 1'b1;

    // Hand-picked numbers. 11222333000181 is a correct number; the typed
    // verdicts follow directly from it. The branch check is on after reset.
    rows.push_back('{"11222333000181", -1, 8'h00, 1'b1, 1'b1, VERDICT_ONE});
    rows.push_back('{"00000000000000", -1, 8'h00, 1'b1, 1'b1, VERDICT_ONE});
    // Wrong second check digit, then wrong first check digit.
    rows.push_back('{"11222333000182", -1, 8'h00, 1'b1, 1'b1, VERDICT_ZERO});
    rows.push_back('{"11222333000171", -1, 8'h00, 1'b1, 1'b1, VERDICT_ZERO});
    // Correct check digits but a nonzero branch: rejected only when checked.
    rows.push_back('{"11222333120160", -1, 8'h00, 1'b1, 1'b1, VERDICT_ZERO});
    rows.push_back('{"11222333120160", -1, 8'h00, 1'b1, 1'b0, VERDICT_ONE});
    // The branch check is switched off halfway through a number, before the
    // branch digits arrive, so the new setting governs them.
    rows.push_back('{"11222333", -1, 8'h00, 1'b0, 1'b1, VERDICT_PREDICTED});
    rows.push_back('{"120160", -1, 8'h00, 1'b1, 1'b0, VERDICT_PREDICTED});
    // Too short, one too long, and long enough to saturate the position.
    rows.push_back('{"1122233300018", -1, 8'h00, 1'b1, 1'b0, VERDICT_ZERO});
    rows.push_back('{"112223330001810", -1, 8'h00, 1'b1, 1'b0, VERDICT_ZERO});
    rows.push_back('{"11222333000181000", -1, 8'h00, 1'b1, 1'b0, VERDICT_ZERO});
    rows.push_back('{"7", -1, 8'h00, 1'b1, 1'b0, VERDICT_ZERO});
    // Non-digits: both byte extremes and the neighbors of the digit range.
    rows.push_back('{"11222333000181", 4, 8'h00, 1'b1, 1'b0, VERDICT_ZERO});
    rows.push_back('{"11222333000181", 13, 8'hFF, 1'b1, 1'b0, VERDICT_ZERO});
    rows.push_back('{"11222333000181", 0, 8'h2F, 1'b1, 1'b0, VERDICT_ZERO});
    rows.push_back('{"11222333000181", 7, 8'h3A, 1'b1, 1'b0, VERDICT_ZERO});
    // Assorted numbers whose verdicts come from the model, including sums
    // with a remainder below two.
    rows.push_back('{"12345678000195", -1, 8'h00, 1'b1, 1'b1, VERDICT_PREDICTED});
    rows.push_back('{"99999999000191", -1, 8'h00, 1'b1, 1'b1, VERDICT_PREDICTED});
    rows.push_back('{"00000001000100", -1, 8'h00, 1'b1, 1'b1, VERDICT_PREDICTED});
    rows.push_back('{"98765432100010", -1, 8'h00, 1'b1, 1'b0, VERDICT_PREDICTED});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].branch_en != branch_zero_en) write_branch_check(rows[i].branch_en);
      len = rows[i].text.len();
      for (int k = 0; k < len; k++) begin
        ch = (k == rows[i].sub_pos) ? rows[i].sub_char : cdv_pkg::char_t'(rows[i].text[k]);
        push_char(ch, rows[i].mark_last && k == len - 1, rows[i].kind);
      end
    end

    // Random phases. Each one starts with a register write; one phase in four
    // runs with no idling at all, and another holds every number back until
    // the previous verdict has come out.
    start_count = chars_sent;
    phase = 0;
    while (chars_sent < start_count + RANDOM_CHARS) begin
      if (phase == 0)
        write_branch_check(1'b0);
      else if (phase % 3 == 1)
        write_branch_check(1'b1);
      else
        write_branch_check(1'($urandom_range(1)));
      idle_free = (phase % 4 == 2);
      for (int n = 0; n < 8; n++) begin
        if (phase % 4 == 1 && verdict_q.size() != 0) begin
          in_valid <= 1'b0;
          while (verdict_q.size() != 0) @(posedge clk);
        end
        send_random_number();
      end
      phase++;
    end
    idle_free = 1'b0;
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cdv_pkg.sv
sv/cnpj_check_digit_validator.sv
sv/cdv_checker.sv
verif/testbench.sv
